[hw/rtl/slid_pkg.sv]
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants of the sorted list insert/delete unit.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 5;
    localparam int STATUS_W      = 2;
    localparam int OUT_TDATA_W   = 40;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic [COUNT_W-1:0]         count;
        logic signed [DATA_W-1:0]   smallest;
    } res_t;

endpackage

[hw/rtl/slid_ram.sv]
// ----------------------------------------------------------------------------
// slid_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/slid_ctrl.sv]
// ----------------------------------------------------------------------------
// slid_ctrl
// Sequencer that scans and shifts the ordered store one entry at a time
// through the RAM, and keeps the fill count and a copy of the head entry.
// ----------------------------------------------------------------------------
module slid_ctrl #(
    parameter int DEPTH = slid_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_op,
    input  logic signed [slid_pkg::DATA_W-1:0] in_value,
    output logic                             res_valid,
    input  logic                             res_ready,
    output slid_pkg::res_t                   res,
    output logic                             mem_we,
    output logic [$clog2(DEPTH)-1:0]         mem_waddr,
    output logic [slid_pkg::DATA_W-1:0]      mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(DEPTH)-1:0]         mem_raddr,
    input  logic [slid_pkg::DATA_W-1:0]      mem_rdata
);

    import slid_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_RD   = 8'b0000_0010,
        S_INS_EV   = 8'b0000_0100,
        S_SRCH_RD  = 8'b0000_1000,
        S_SRCH_EV  = 8'b0001_0000,
        S_SHIFT_RD = 8'b0010_0000,
        S_SHIFT_EV = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic [FW-1:0]            ptr_reg, ptr_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] head_reg, head_next;
    status_t                  status_reg, status_next;
    logic [FW-1:0]            ptr_inc;
    logic [FW-1:0]            ptr_dec;

    assign ptr_inc = ptr_reg + 1'b1;
    assign ptr_dec = ptr_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg[AW-1:0];
        mem_wdata   = value_reg;
        mem_re      = 1'b0;
        mem_raddr   = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next  = in_value;
                    ptr_next    = '0;
                    status_next = ST_OK;
                    if (in_op == OP_INSERT)
                    begin
                        if (fill_reg == FILL_MAX)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = fill_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    mem_we     = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_dec[AW-1:0];
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV:
            begin
                mem_we = 1'b1;
                if ($signed(mem_rdata) >= value_reg)
                begin
                    mem_wdata  = mem_rdata;
                    ptr_next   = ptr_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SRCH_RD:
            begin
                if (ptr_reg == fill_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SRCH_EV;
                end
            end
            S_SRCH_EV:
            begin
                if (mem_rdata == value_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (ptr_inc == fill_reg)
                begin
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_inc[AW-1:0];
                    state_next = S_SHIFT_EV;
                end
            end
            S_SHIFT_EV:
            begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_inc;
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (mem_we && (ptr_reg == '0))
        begin
            head_next = mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        value_reg  <= value_next;
        head_reg   <= head_next;
        status_reg <= status_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.status     = status_reg;
    assign res.count      = COUNT_W'(fill_reg);
    assign res.smallest   = (fill_reg != '0) ? head_reg : '0;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count above depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status_reg == ST_FULL)) |-> (fill_reg == FILL_MAX))
        else $error("full status with free entries");

    a_not_found_scanned: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status_reg == ST_NOT_FOUND)) |-> (ptr_reg == fill_reg))
        else $error("not found before scanning all entries");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (ptr_reg < FILL_MAX))
        else $error("store write beyond depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (state_reg == S_DONE))
        else $error("fill changed outside item completion");
`endif

endmodule

[hw/rtl/sorted_list_insert_delete_unit.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// Ascending ordered store of signed words with insert and delete of one
// value per input word and one result word per item.
// ----------------------------------------------------------------------------
// Operation: an insert walks down from the top and a delete scans up from
//   the bottom, one visited entry at a time on the single RAM read port.
// Throughput: one item at a time; next input word taken once the result is
//   in the output register.
// Reset: asynchronous, clears fill count and control; RAM contents undefined.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit #(
    parameter int DEPTH = slid_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [slid_pkg::DATA_W-1:0]           s_tdata,  // [31:0] value
    input  logic                                  s_tuser,  // [0] op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [slid_pkg::OUT_TDATA_W-1:0]      m_tdata   // [1:0] status,
                                                            // [6:2] count,
                                                            // [38:7] smallest
);

    import slid_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [DATA_W-1:0]    mem_rdata;

    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg, out_res_next;

    slid_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  ($signed(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    slid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.smallest, out_res_reg.count, out_res_reg.status};

endmodule

[verif/sorted_list_checker.sv]
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches both stream channels of the sorted list unit. Each accepted input
// word is run through a local ordered list to produce the expected result
// word; each accepted output word is compared field by field with the oldest
// expected one. Mismatches, unexpected words and the number of results still
// awaited are handed back to the testbench top.
// ----------------------------------------------------------------------------
module sorted_list_checker #(
    parameter int DEPTH = slid_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [slid_pkg::DATA_W-1:0]         s_tdata,   // [31:0] value
    input  logic                                s_tuser,   // [0] op
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [slid_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [1:0] status,
                                                           // [6:2] count,
                                                           // [38:7] smallest
    output int                                  errors,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import slid_pkg::*;

    logic signed [DATA_W-1:0] shadow_list [DEPTH];
    int                       shadow_fill;
    res_t                     expected_results [$];
    int                       err_count = 0;

    assign errors = err_count;

    function automatic res_t apply_list_op(input logic op,
                                           input logic signed [DATA_W-1:0] v);
        res_t r;
        int   pos;
        int   k;
        r.status = ST_OK;
        pos = 0;
        if (op == OP_INSERT)
        begin
            if (shadow_fill >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                while (pos < shadow_fill && shadow_list[pos] < v)
                    pos++;
                for (k = shadow_fill; k > pos; k--)
                    shadow_list[k] = shadow_list[k-1];
                shadow_list[pos] = v;
                shadow_fill++;
            end
        end
        else
        begin
            while (pos < shadow_fill && shadow_list[pos] != v)
                pos++;
            if (pos >= shadow_fill)
            begin
                r.status = ST_NOT_FOUND;
            end
            else
            begin
                for (k = pos; k + 1 < shadow_fill; k++)
                    shadow_list[k] = shadow_list[k+1];
                shadow_fill--;
            end
        end
        r.count    = COUNT_W'(shadow_fill);
        r.smallest = (shadow_fill > 0) ? shadow_list[0] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h",
                 $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            shadow_fill = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status   = status_t'(m_tdata[1:0]);
                got.count    = m_tdata[6:2];
                got.smallest = m_tdata[38:7];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result word", m_tdata[38:7], '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                    if (got.smallest !== want.smallest)
                        report_mismatch("smallest", got.smallest, want.smallest);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_list_op(s_tuser, s_tdata));
            outstanding <= expected_results.size();
        end
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench top for the sorted list insert/delete unit. Drives a directed
// run over empty, full, duplicate and extreme values, then random inserts
// and deletes with phases of sender and receiver idling. Checking is done
// by sorted_list_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slid_pkg::*;

    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS  = 1500;
    localparam int PHASE_WORDS   = RANDOM_WORDS / 3;
    localparam int DRAIN_CYCLES  = 2 * DEPTH + 40;
    localparam int LIMIT_CYCLES  = 1_000_000;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [DATA_W-1:0]         s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_tdata;

    int errors;
    int outstanding;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    sorted_list_insert_delete_unit #(
        .DEPTH    (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_list_checker #(
        .DEPTH       (DEPTH)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_word(input logic op_i, input logic [DATA_W-1:0] val_i);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op_i;
        s_tdata  <= val_i;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off the sender until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'h8000_0000;
            default: v = $urandom_range(0, 8) - 4;
        endcase
        return v;
    endfunction

    initial
    begin
        int i;
        int phase;
        int ins_pct;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_INSERT;
        rst_n    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 25;
        rx_idle_pct = 80;

        send_word(OP_DELETE, 32'd0);
        send_word(OP_INSERT, 32'h7FFF_FFFF);
        send_word(OP_INSERT, 32'h8000_0000);
        send_word(OP_INSERT, 32'd0);
        send_word(OP_INSERT, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 32'd1);
        send_word(OP_INSERT, 32'h8000_0000);
        send_word(OP_DELETE, 32'd5);
        send_word(OP_DELETE, 32'h8000_0000);
        for (i = 0; i < 10; i++)
            send_word(OP_INSERT, 32'(i * 7 - 30));
        send_word(OP_INSERT, 32'd3);
        send_word(OP_DELETE, 32'h7FFF_FFFF);
        send_word(OP_DELETE, 32'h8000_0000);
        send_word(OP_DELETE, 32'd0);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 25; rx_idle_pct = 80; end
                1:       begin tx_idle_pct = 80; rx_idle_pct = 25; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                // swing between filling up and draining out
                case ((i / 60) % 3)
                    0:       ins_pct = 75;
                    1:       ins_pct = 50;
                    default: ins_pct = 25;
                endcase
                send_word(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE,
                          pick_value());
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
